@@ hw/rtl/srle_pkg.sv @@
// shared types and constants of the sound register log encoder
package srle_pkg;

  localparam int unsigned CntW = 32;
  localparam logic [CntW-1:0] CntReset = 32'd11;

  localparam logic [7:0] SyncOne  = 8'hFF;
  localparam logic [7:0] SyncLong = 8'hFE;
  localparam logic [7:0] EndMark  = 8'hFD;
  localparam logic [6:0] GrpMask  = 7'h7F;
  localparam logic [7:0] ContBit  = 8'h80;
  localparam int unsigned GrpW    = 7;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FF2,
    ST_FF1,
    ST_FE,
    ST_GRP,
    ST_MOD,
    ST_ADDR,
    ST_DATA,
    ST_END
  } seq_state_e;

  typedef struct packed {
    logic inc;
    logic clr;
  } cnt_ctrl_t;

endpackage

@@ hw/rtl/srle_in_if.sv @@
// input channel of the log encoder: action and write fields
interface srle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] module_req;
  logic [7:0] reg_addr;
  logic [7:0] value;

  modport source (output valid, action, module_req, reg_addr, value, input ready);
  modport sink (input valid, action, module_req, reg_addr, value, output ready);
endinterface

@@ hw/rtl/srle_out_if.sv @@
// output channel of the log encoder: one stream byte per item
interface srle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

@@ hw/rtl/sound_register_log_encoder.sv @@
// top level of the sound register log encoder
// in_i carries timer ticks, register writes and the end mark; out_o carries the
// encoded log stream, one byte per item, with last set on the final byte of an input.
// a tick only bumps the pending tick count (saturating at 2^32-1).
// a write or end mark is taken only while the sequencer is idle; it flushes the count
// as FF, FF FF, or FE plus 7-bit groups, then emits module, address and data, or FD.
// the sequencer state registers the item, then loads one byte per cycle into the output
// register while out_o is not stalled, shifting the count out seven bits at a time.
// once the end mark is taken, every later item is taken and dropped.
// reset clears the output valid, sets the count to 11 and opens the log.
// a stalled out_o holds its byte; the sequencer waits and in_i stays not ready
// until the pending bytes have been loaded into the output register.
module sound_register_log_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  srle_in_if.sink    in_i,
  srle_out_if.source out_o
);

  srle_pkg::cnt_ctrl_t        cnt_ctrl;
  logic [srle_pkg::CntW-1:0]  count;
  logic                       seq_idle;
  logic                       log_open_q;
  logic                       in_acc;
  logic                       start;
  srle_pkg::action_e          act;

  assign act    = srle_pkg::action_e'(in_i.action);
  assign in_i.ready = seq_idle;
  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    cnt_ctrl = '0;
    start    = 1'b0;
    if (in_acc && log_open_q) begin
      case (act)
        srle_pkg::ACT_TICK: begin
          cnt_ctrl.inc = 1'b1;
        end
        srle_pkg::ACT_WRITE, srle_pkg::ACT_END: begin
          cnt_ctrl.clr = 1'b1;
          start        = 1'b1;
        end
        default: begin
          start = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_open_q <= 1'b1;
    end else if (start && (act == srle_pkg::ACT_END)) begin
      log_open_q <= 1'b0;
    end
  end

  srle_cnt u_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cnt_ctrl),
    .count_o (count)
  );

  srle_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .is_end_i (act == srle_pkg::ACT_END),
    .count_i  (count),
    .mod_i    (in_i.module_req),
    .addr_i   (in_i.reg_addr),
    .data_i   (in_i.value),
    .idle_o   (seq_idle),
    .out_o    (out_o)
  );

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && (act == srle_pkg::ACT_END)) |=> !log_open_q)
    else $error("log still open after end mark");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (count == '0) && !seq_idle)
    else $error("flush did not clear count or start sequencer");

  a_closed_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!log_open_q && seq_idle) |=> $stable(count) && seq_idle)
    else $error("closed log changed state");

endmodule

@@ hw/rtl/srle_cnt.sv @@
// saturating counter of pending timer ticks
module srle_cnt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srle_pkg::cnt_ctrl_t           ctrl_i,
  output logic [srle_pkg::CntW-1:0]     count_o
);

  logic [srle_pkg::CntW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clr) begin
      count_d = '0;
    end else if (ctrl_i.inc && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= srle_pkg::CntReset;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

@@ hw/rtl/srle_seq.sv @@
// byte sequencer: sync code, 7-bit group shifter, write or end bytes, output register
module srle_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      is_end_i,
  input  logic [srle_pkg::CntW-1:0] count_i,
  input  logic [7:0]                mod_i,
  input  logic [7:0]                addr_i,
  input  logic [7:0]                data_i,
  output logic                      idle_o,
  srle_out_if.source                out_o
);

  srle_pkg::seq_state_e state_q, state_d;
  logic [srle_pkg::CntW-1:0] grp_q, grp_d;
  logic [7:0] mod_q, addr_q, data_q;
  logic       is_end_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       adv;
  logic       emit;
  logic [7:0] byte_n;
  logic       last_n;
  logic       grp_more;

  assign adv      = !out_valid_q || out_o.ready;
  assign grp_more = |grp_q[srle_pkg::CntW-1:srle_pkg::GrpW];

  always_comb begin
    state_d = state_q;
    grp_d   = grp_q;
    emit    = 1'b0;
    byte_n  = srle_pkg::SyncOne;
    last_n  = 1'b0;
    case (state_q)
      srle_pkg::ST_IDLE: begin
        if (start_i) begin
          grp_d = count_i - srle_pkg::CntW'(2);
          if (count_i == '0) begin
            state_d = is_end_i ? srle_pkg::ST_END : srle_pkg::ST_MOD;
          end else if (count_i == srle_pkg::CntW'(1)) begin
            state_d = srle_pkg::ST_FF1;
          end else if (count_i == srle_pkg::CntW'(2)) begin
            state_d = srle_pkg::ST_FF2;
          end else begin
            state_d = srle_pkg::ST_FE;
          end
        end
      end
      srle_pkg::ST_FF2: begin
        if (adv) begin
          emit    = 1'b1;
          state_d = srle_pkg::ST_FF1;
        end
      end
      srle_pkg::ST_FF1: begin
        if (adv) begin
          emit    = 1'b1;
          state_d = is_end_q ? srle_pkg::ST_END : srle_pkg::ST_MOD;
        end
      end
      srle_pkg::ST_FE: begin
        byte_n = srle_pkg::SyncLong;
        if (adv) begin
          emit    = 1'b1;
          state_d = srle_pkg::ST_GRP;
        end
      end
      srle_pkg::ST_GRP: begin
        byte_n = {1'b0, grp_q[srle_pkg::GrpW-1:0] & srle_pkg::GrpMask};
        if (grp_more) begin
          byte_n = byte_n | srle_pkg::ContBit;
        end
        if (adv) begin
          emit = 1'b1;
          if (grp_more) begin
            grp_d = grp_q >> srle_pkg::GrpW;
          end else begin
            state_d = is_end_q ? srle_pkg::ST_END : srle_pkg::ST_MOD;
          end
        end
      end
      srle_pkg::ST_MOD: begin
        byte_n = mod_q;
        if (adv) begin
          emit    = 1'b1;
          state_d = srle_pkg::ST_ADDR;
        end
      end
      srle_pkg::ST_ADDR: begin
        byte_n = addr_q;
        if (adv) begin
          emit    = 1'b1;
          state_d = srle_pkg::ST_DATA;
        end
      end
      srle_pkg::ST_DATA: begin
        byte_n = data_q;
        last_n = 1'b1;
        if (adv) begin
          emit    = 1'b1;
          state_d = srle_pkg::ST_IDLE;
        end
      end
      srle_pkg::ST_END: begin
        byte_n = srle_pkg::EndMark;
        last_n = 1'b1;
        if (adv) begin
          emit    = 1'b1;
          state_d = srle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srle_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    if (adv) begin
      out_byte_q <= byte_n;
      out_last_q <= last_n;
    end
    if (start_i) begin
      mod_q    <= mod_i;
      addr_q   <= addr_i;
      data_q   <= data_i;
      is_end_q <= is_end_i;
    end
  end

  assign idle_o       = (state_q == srle_pkg::ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// testbench of the sound register log encoder: ticks, writes and end mark checked byte by byte
module tb;

  localparam logic [1:0]  ActUnused    = 2'd3;
  localparam int unsigned IdlePct      = 33;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned HoldAtByte   = 20;
  localparam int unsigned CalmFrom     = 60;
  localparam int unsigned CalmTo       = 130;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomItems  = 140;

  typedef struct {
    logic [1:0] act;
    logic [7:0] mod_b;
    logic [7:0] addr_b;
    logic [7:0] data_b;
    bit         drain_first;
  } log_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srle_in_if  in_if ();
  srle_out_if out_if ();

  sound_register_log_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  log_cmd_t     pending_cmds[$];
  stream_byte_t expected_bytes[$];

  logic [31:0] ticks_owed;
  logic        log_live;

  int unsigned mismatches;
  int unsigned bytes_seen;
  int unsigned items_in;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_done;
  bit          calm;

  assign calm = (items_in >= CalmFrom) && (items_in < CalmTo);

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    stream_byte_t sb;
    sb.data = b;
    sb.last = 1'b0;
    expected_bytes.push_back(sb);
  endfunction

  // pending ticks go out as FF, FF FF, or FE plus 7-bit groups
  function automatic void flush_sync();
    logic [31:0] rem;
    if (ticks_owed == 32'd1) begin
      queue_byte(srle_pkg::SyncOne);
    end else if (ticks_owed == 32'd2) begin
      queue_byte(srle_pkg::SyncOne);
      queue_byte(srle_pkg::SyncOne);
    end else if (ticks_owed > 32'd2) begin
      queue_byte(srle_pkg::SyncLong);
      rem = ticks_owed - 32'd2;
      while (rem > 32'(srle_pkg::GrpMask)) begin
        queue_byte(srle_pkg::ContBit | {1'b0, rem[6:0]});
        rem = rem >> srle_pkg::GrpW;
      end
      queue_byte({1'b0, rem[6:0]});
    end
    ticks_owed = '0;
  endfunction

  function automatic void encode_cmd(logic [1:0] act, logic [7:0] m, logic [7:0] a,
                                     logic [7:0] d);
    if (log_live) begin
      case (act)
        srle_pkg::ACT_TICK: begin
          if (ticks_owed != '1) ticks_owed = ticks_owed + 32'd1;
        end
        srle_pkg::ACT_WRITE: begin
          flush_sync();
          queue_byte(m);
          queue_byte(a);
          queue_byte(d);
          expected_bytes[expected_bytes.size()-1].last = 1'b1;
        end
        srle_pkg::ACT_END: begin
          flush_sync();
          queue_byte(srle_pkg::EndMark);
          expected_bytes[expected_bytes.size()-1].last = 1'b1;
          log_live = 1'b0;
        end
        default: begin
        end
      endcase
    end
  endfunction

  function automatic void add_cmd(logic [1:0] act, logic [7:0] m, logic [7:0] a,
                                  logic [7:0] d, bit drain = 1'b0);
    log_cmd_t c;
    c.act         = act;
    c.mod_b       = m;
    c.addr_b      = a;
    c.data_b      = d;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endfunction

  function automatic void add_ticks(int unsigned k);
    for (int unsigned i = 0; i < k; i++) begin
      add_cmd(srle_pkg::ACT_TICK, rand_byte(), rand_byte(), rand_byte());
    end
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        encode_cmd(in_if.action, in_if.module_req, in_if.reg_addr, in_if.value);
        void'(pending_cmds.pop_front());
        items_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_cmds.size() != 0
            && !(pending_cmds[0].drain_first && expected_bytes.size() != 0)
            && !(!calm && hold_left == 0 && $urandom_range(0, 99) < IdlePct)) begin
          in_if.valid      <= 1'b1;
          in_if.action     <= pending_cmds[0].act;
          in_if.module_req <= pending_cmds[0].mod_b;
          in_if.reg_addr   <= pending_cmds[0].addr_b;
          in_if.value      <= pending_cmds[0].data_b;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : out_mon
    stream_byte_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected byte %02h last %0b", out_if.out_byte, out_if.last);
        end else begin
          want = expected_bytes.pop_front();
          if (out_if.out_byte !== want.data || out_if.last !== want.last) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("byte %0d: expected %02h last %0b, got %02h last %0b", bytes_seen,
                       want.data, want.last, out_if.out_byte, out_if.last);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && bytes_seen >= HoldAtByte) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned r;
    bit          big_done;
    bit          drain_done;
    bit          drain;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = srle_pkg::ACT_TICK;
    in_if.module_req = 8'h00;
    in_if.reg_addr   = 8'h00;
    in_if.value      = 8'h00;
    out_if.ready     = 1'b0;
    ticks_owed       = srle_pkg::CntReset;
    log_live         = 1'b1;
    mismatches       = 0;
    bytes_seen       = 0;
    items_in         = 0;
    quiet_cycles     = 0;
    hold_left        = 0;
    hold_done        = 1'b0;
    big_done         = 1'b0;
    drain_done       = 1'b0;
    drain            = 1'b0;

    // reset count flush, then zero, one, two and several pending ticks
    add_cmd(srle_pkg::ACT_WRITE, 8'h00, 8'h00, 8'h00);
    add_cmd(srle_pkg::ACT_WRITE, 8'hFF, 8'hFF, 8'hFF);
    add_cmd(srle_pkg::ACT_TICK, 8'hFF, 8'hFF, 8'hFF);
    add_cmd(srle_pkg::ACT_WRITE, 8'h55, 8'hAA, 8'h55);
    add_ticks(2);
    add_cmd(srle_pkg::ACT_WRITE, 8'hAA, 8'h55, 8'hAA);
    add_ticks(3);
    add_cmd(srle_pkg::ACT_WRITE, 8'h01, 8'h80, 8'h7F);
    add_cmd(ActUnused, 8'hFF, 8'hFF, 8'hFF);
    add_cmd(ActUnused, 8'h00, 8'h00, 8'h00);
    add_cmd(srle_pkg::ACT_WRITE, rand_byte(), rand_byte(), rand_byte());
    add_ticks(4);
    add_cmd(srle_pkg::ACT_WRITE, rand_byte(), rand_byte(), rand_byte());

    n = 0;
    while (n < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_cmd(ActUnused, rand_byte(), rand_byte(), rand_byte());
        n++;
      end else begin
        if (!big_done && n >= 10) begin
          // two group bytes
          big_done = 1'b1;
          k = 130 + $urandom_range(0, 4);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 30) k = 0;
          else if (r < 60) k = $urandom_range(1, 2);
          else k = $urandom_range(3, 12);
        end
        drain = !drain_done && (n >= 4);
        if (drain) drain_done = 1'b1;
        add_ticks(k);
        add_cmd(srle_pkg::ACT_WRITE, rand_byte(), rand_byte(), rand_byte(), drain);
        n += k + 1;
      end
    end

    // end mark, then items the closed log drops
    add_ticks($urandom_range(3, 12));
    add_cmd(srle_pkg::ACT_END, rand_byte(), rand_byte(), rand_byte());
    add_cmd(srle_pkg::ACT_WRITE, rand_byte(), rand_byte(), rand_byte());
    add_ticks(3);
    add_cmd(ActUnused, rand_byte(), rand_byte(), rand_byte());
    add_cmd(srle_pkg::ACT_END, rand_byte(), rand_byte(), rand_byte());
    add_cmd(srle_pkg::ACT_WRITE, rand_byte(), rand_byte(), rand_byte());

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && !in_if.valid);
    wait (expected_bytes.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
